@@ rtl/egcn_pkg.sv @@
// ============================================================================
// egcn_pkg
// Shared types and constants for the eigen-gap condition number block.
// ============================================================================
package egcn_pkg;

    localparam int DEF_MAX_VALUES = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int SEP_BITS       = 31;
    localparam int IDX_BITS       = 6;
    localparam int RUN_BITS       = 7;   // width of row/col counts, bounds k
    localparam int MODE_BITS      = 2;
    localparam int EPS_BITS       = 5;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [SEP_BITS-1:0] SEP_MAX = '1;

    // mode register codes
    localparam logic [MODE_BITS-1:0] MODE_EIGEN = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LEFT  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE      = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COL_COUNT = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EPS_SHIFT = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SEP   = 8'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // one finished run, handed from loader to compute engine
    typedef struct packed {
        logic                 err;
        logic                 bank;
        logic [RUN_BITS-1:0]  k;
        logic                 clip_first;
        logic                 clip_last;
        logic [SEP_BITS-1:0]  first_mag;
        logic [SEP_BITS-1:0]  last_mag;
        logic [EPS_BITS-1:0]  eps_shift;
        logic [SEP_BITS-1:0]  min_sep;
    } job_t;

    // engine tells loader a buffer bank is free again
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_LOAD0,
        B_CALC,
        B_EMIT,
        B_ERR
    } back_state_t;

endpackage

@@ rtl/eigen_gap_condition_numbers.sv @@
// ============================================================================
// eigen_gap_condition_numbers
// Eigenvector / singular vector reciprocal condition numbers from a sorted
// run of Q16.16 values: neighbor gaps, edge clipping and threshold clamp.
// ============================================================================
//
//  channel   ports                                     moves
//  --------  ----------------------------------------  -------------------------
//  config    cfg_we, cfg_index, cfg_data               register write, no wait
//  input     s_valid/s_ready, s_value                  one value request
//  result    m_valid/m_ready, m_separation, m_index,   one separation or error
//            m_status, m_last
//
//  Loading accepts a value whenever the target buffer bank is free.
//  The engine sets up with pop, first read and first load, then forms
//  each result by gap calc and emit; an error run only pops and emits.
//  Two banks let the next run load while the previous one drains.
//  Reset is synchronous, active low; no clearing pass (buffer is read-first).
//  Stalls on m_ready hold the engine; s_ready drops only while both banks
//  hold unfinished runs.
// ============================================================================
module eigen_gap_condition_numbers #(
    parameter int MAX_VALUES = egcn_pkg::DEF_MAX_VALUES,
    parameter int VALUE_BITS = egcn_pkg::DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [egcn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [egcn_pkg::SEP_BITS-1:0]       cfg_data,
    // value requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [VALUE_BITS-1:0]        s_value,
    // result requests
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [egcn_pkg::SEP_BITS-1:0]       m_separation,
    output logic [egcn_pkg::IDX_BITS-1:0]       m_index,
    output logic                                m_status,
    output logic                                m_last
);

    localparam int AW        = $clog2(MAX_VALUES);
    // two banks of a power-of-two size, indexed by {bank, position}
    localparam int RAM_DEPTH = 2 * (1 << AW);

    logic                  ram_we;
    logic [AW:0]           ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW:0]           ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                  push;
    egcn_pkg::job_t        push_job;
    logic                  pop;
    egcn_pkg::job_t        head_job;
    logic                  q_empty;
    logic                  q_full;
    egcn_pkg::done_t       done;

    // front: config registers, order tracking, buffer writes
    egcn_front #(
        .MAX_VALUES (MAX_VALUES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .job       (push_job),
        .done      (done)
    );

    // value buffer, two banks
    egcn_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // completed runs waiting for the engine
    egcn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: gap walk and result register
    egcn_back #(
        .MAX_VALUES (MAX_VALUES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_job     (head_job),
        .q_empty      (q_empty),
        .pop          (pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_separation (m_separation),
        .m_index      (m_index),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    // a bank is only released after its job left the queue
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("run completed with no queue room");

endmodule

@@ rtl/egcn_ram.sv @@
// ============================================================================
// egcn_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module egcn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/egcn_queue.sv @@
// ============================================================================
// egcn_queue
// Two-entry job queue between loader and compute engine.
// ============================================================================
module egcn_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  egcn_pkg::job_t push_job,
    input  logic           pop,
    output egcn_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    egcn_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job queue underflow");

endmodule

@@ rtl/egcn_front.sv @@
// ============================================================================
// egcn_front
// Loader: holds config, writes values into a buffer bank, tracks order,
// and queues a job descriptor when a run is complete.
// ============================================================================
module egcn_front #(
    parameter int MAX_VALUES = egcn_pkg::DEF_MAX_VALUES,
    parameter int VALUE_BITS = egcn_pkg::DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [egcn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [egcn_pkg::SEP_BITS-1:0]       cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [VALUE_BITS-1:0]        s_value,
    output logic                                ram_we,
    output logic [$clog2(MAX_VALUES):0]         ram_waddr,
    output logic [VALUE_BITS-1:0]               ram_wdata,
    output logic                                push,
    output egcn_pkg::job_t                      job,
    input  egcn_pkg::done_t                     done
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int KW = $clog2(MAX_VALUES + 1);
    localparam int VW = VALUE_BITS;
    localparam int SB = egcn_pkg::SEP_BITS;
    localparam int WW = (VW + 1 > SB) ? VW + 1 : SB;

    function automatic logic [SB-1:0] mag_sat(input logic signed [VW-1:0] x);
        logic [VW:0]   ext;
        logic [VW:0]   a;
        logic [WW-1:0] w;
        ext = {x[VW-1], x};
        a   = x[VW-1] ? (~ext + (VW+1)'(1)) : ext;
        w   = WW'(a);
        if (w > WW'(egcn_pkg::SEP_MAX)) begin
            return egcn_pkg::SEP_MAX;
        end
        return SB'(w);
    endfunction

    // configuration
    logic [egcn_pkg::MODE_BITS-1:0] mode_reg;
    logic [egcn_pkg::RUN_BITS-1:0]  row_count_reg;
    logic [egcn_pkg::RUN_BITS-1:0]  col_count_reg;
    logic [egcn_pkg::EPS_BITS-1:0]  eps_shift_reg;
    logic [SB-1:0]                  min_sep_reg;

    // run tracking
    logic [KW-1:0]          load_count_reg;
    logic                   rising_reg;
    logic                   falling_reg;
    logic                   bank_reg;
    logic [1:0]             bank_busy_reg;
    logic [1:0]             bank_busy_next;
    logic signed [VW-1:0]   prev_reg;
    logic                   first_neg_reg;
    logic [SB-1:0]          first_mag_reg;

    logic                          sing;
    logic                          clip;
    logic [egcn_pkg::RUN_BITS-1:0] rk;
    logic [KW-1:0]                 run_k;
    logic [KW-1:0]                 cnt;
    logic                          accept;
    logic                          do_load;
    logic                          complete;
    logic                          rising_n;
    logic                          falling_n;
    logic                          first_neg;
    logic [SB-1:0]                 first_mag;
    logic [SB-1:0]                 cur_mag;
    logic                          inc;
    logic                          dec;

    always_comb begin
        sing = (mode_reg == egcn_pkg::MODE_LEFT) || (mode_reg == egcn_pkg::MODE_RIGHT);
        clip = ((mode_reg == egcn_pkg::MODE_LEFT)  && (row_count_reg > col_count_reg)) ||
               ((mode_reg == egcn_pkg::MODE_RIGHT) && (row_count_reg < col_count_reg));
        if (sing && (col_count_reg < row_count_reg)) begin
            rk = col_count_reg;
        end else begin
            rk = row_count_reg;
        end
        if (32'(rk) > 32'(MAX_VALUES)) begin
            run_k = KW'(MAX_VALUES);
        end else begin
            run_k = KW'(rk);
        end

        // a partial run that no longer fits the length is dropped
        cnt = (load_count_reg >= run_k) ? '0 : load_count_reg;

        accept  = s_valid && s_ready;
        do_load = accept && (run_k != '0);
        complete = (({1'b0, cnt} + (KW+1)'(1)) == {1'b0, run_k});

        if (cnt == '0) begin
            rising_n  = 1'b1;
            falling_n = 1'b1;
            first_neg = s_value[VW-1];
            first_mag = mag_sat(s_value);
        end else begin
            rising_n  = rising_reg  && !(prev_reg > s_value);
            falling_n = falling_reg && !(prev_reg < s_value);
            first_neg = first_neg_reg;
            first_mag = first_mag_reg;
        end
        cur_mag = mag_sat(s_value);

        inc = rising_n  && !(sing && first_neg);
        dec = falling_n && !(sing && s_value[VW-1]);
    end

    assign s_ready   = !bank_busy_reg[bank_reg];
    assign ram_we    = do_load;
    assign ram_waddr = {bank_reg, AW'(cnt)};
    assign ram_wdata = s_value;
    assign push      = do_load && complete;

    always_comb begin
        job.err        = !inc && !dec;
        job.bank       = bank_reg;
        job.k          = egcn_pkg::RUN_BITS'(run_k);
        job.clip_first = clip && inc;
        job.clip_last  = clip && dec;
        job.first_mag  = first_mag;
        job.last_mag   = cur_mag;
        job.eps_shift  = eps_shift_reg;
        job.min_sep    = min_sep_reg;
    end

    always_comb begin
        bank_busy_next = bank_busy_reg;
        if (done.valid) begin
            bank_busy_next[done.bank] = 1'b0;
        end
        if (push) begin
            bank_busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= egcn_pkg::MODE_EIGEN;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            eps_shift_reg  <= egcn_pkg::EPS_BITS'(16);
            min_sep_reg    <= SB'(1);
            load_count_reg <= '0;
            rising_reg     <= 1'b1;
            falling_reg    <= 1'b1;
            bank_reg       <= 1'b0;
            bank_busy_reg  <= 2'b00;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    egcn_pkg::CFG_MODE:      mode_reg      <= cfg_data[egcn_pkg::MODE_BITS-1:0];
                    egcn_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data[egcn_pkg::RUN_BITS-1:0];
                    egcn_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data[egcn_pkg::RUN_BITS-1:0];
                    egcn_pkg::CFG_EPS_SHIFT: eps_shift_reg <= cfg_data[egcn_pkg::EPS_BITS-1:0];
                    egcn_pkg::CFG_MIN_SEP:   min_sep_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (do_load) begin
                if (complete) begin
                    load_count_reg <= '0;
                    rising_reg     <= 1'b1;
                    falling_reg    <= 1'b1;
                    bank_reg       <= ~bank_reg;
                end else begin
                    load_count_reg <= cnt + KW'(1);
                    rising_reg     <= rising_n;
                    falling_reg    <= falling_n;
                end
            end
            bank_busy_reg <= bank_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            prev_reg      <= s_value;
            first_neg_reg <= first_neg;
            first_mag_reg <= first_mag;
        end
    end

    a_bank_held: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> bank_busy_reg[$past(bank_reg)] && (bank_reg != $past(bank_reg)))
        else $error("queued bank not marked busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, load_count_reg} < (KW+1)'(MAX_VALUES))
        else $error("load count beyond buffer");

endmodule

@@ rtl/egcn_back.sv @@
// ============================================================================
// egcn_back
// Compute engine: walks one buffer bank, forms neighbor gaps, clips and
// clamps each separation, and drives the result register.
// ============================================================================
module egcn_back #(
    parameter int MAX_VALUES = egcn_pkg::DEF_MAX_VALUES,
    parameter int VALUE_BITS = egcn_pkg::DEF_VALUE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  egcn_pkg::job_t                 head_job,
    input  logic                           q_empty,
    output logic                           pop,
    output logic [$clog2(MAX_VALUES):0]    ram_raddr,
    input  logic [VALUE_BITS-1:0]          ram_rdata,
    output egcn_pkg::done_t                done,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [egcn_pkg::SEP_BITS-1:0]  m_separation,
    output logic [egcn_pkg::IDX_BITS-1:0]  m_index,
    output logic                           m_status,
    output logic                           m_last
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int KW = $clog2(MAX_VALUES + 1);
    localparam int VW = VALUE_BITS;
    localparam int SB = egcn_pkg::SEP_BITS;
    localparam int WW = (VW + 1 > SB) ? VW + 1 : SB;

    function automatic logic [SB-1:0] gap_sat(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        logic [VW:0]   diff;
        logic [VW:0]   mag;
        logic [WW-1:0] w;
        diff = {a[VW-1], a} - {b[VW-1], b};
        mag  = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
        w    = WW'(mag);
        if (w > WW'(egcn_pkg::SEP_MAX)) begin
            return egcn_pkg::SEP_MAX;
        end
        return SB'(w);
    endfunction

    egcn_pkg::back_state_t state_reg;
    egcn_pkg::back_state_t state_next;

    egcn_pkg::job_t  job_reg;
    logic [KW-1:0]   k_reg;
    logic [KW-1:0]   idx_reg;
    logic [VW-1:0]   cur_reg;
    logic [VW-1:0]   nxt_reg;
    logic [SB-1:0]   gap_left_reg;
    logic [SB-1:0]   gap_right_reg;
    logic [SB-1:0]   thresh_reg;
    logic            m_valid_reg;

    logic            slot_free;
    logic            is_last;
    logic            has_right;
    logic            out_load;
    logic            out_err;
    logic [SB-1:0]   anorm;
    logic [SB-1:0]   scaled;
    logic [SB-1:0]   sep;

    assign slot_free = !m_valid_reg || m_ready;
    assign is_last   = (({1'b0, idx_reg} + (KW+1)'(1)) == {1'b0, k_reg});
    assign has_right = (({1'b0, idx_reg} + (KW+1)'(1)) <  {1'b0, k_reg});

    // threshold: max(anorm >> eps_shift, min_sep)
    always_comb begin
        anorm  = (job_reg.last_mag > job_reg.first_mag) ? job_reg.last_mag
                                                        : job_reg.first_mag;
        scaled = anorm >> job_reg.eps_shift;
    end

    // separation of the current value
    always_comb begin
        sep = (gap_right_reg < gap_left_reg) ? gap_right_reg : gap_left_reg;
        if ((idx_reg == '0) && job_reg.clip_first && (job_reg.first_mag < sep)) begin
            sep = job_reg.first_mag;
        end
        if (is_last && job_reg.clip_last && (job_reg.last_mag < sep)) begin
            sep = job_reg.last_mag;
        end
        if (sep < thresh_reg) begin
            sep = thresh_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            egcn_pkg::B_IDLE: begin
                if (!q_empty) begin
                    state_next = head_job.err ? egcn_pkg::B_ERR : egcn_pkg::B_START;
                end
            end
            egcn_pkg::B_START: state_next = egcn_pkg::B_LOAD0;
            egcn_pkg::B_LOAD0: state_next = egcn_pkg::B_CALC;
            egcn_pkg::B_CALC:  state_next = egcn_pkg::B_EMIT;
            egcn_pkg::B_EMIT: begin
                if (slot_free) begin
                    state_next = is_last ? egcn_pkg::B_IDLE : egcn_pkg::B_CALC;
                end
            end
            egcn_pkg::B_ERR: begin
                if (slot_free) begin
                    state_next = egcn_pkg::B_IDLE;
                end
            end
            default: state_next = egcn_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop        = 1'b0;
        out_load   = 1'b0;
        out_err    = 1'b0;
        done.valid = 1'b0;
        done.bank  = job_reg.bank;
        ram_raddr  = {job_reg.bank, AW'(0)};
        case (state_reg)
            egcn_pkg::B_IDLE: begin
                pop = !q_empty;
            end
            egcn_pkg::B_START: begin
                ram_raddr = {job_reg.bank, AW'(0)};
            end
            egcn_pkg::B_LOAD0: begin
                ram_raddr = {job_reg.bank, AW'(1)};
            end
            egcn_pkg::B_CALC: ;
            egcn_pkg::B_EMIT: begin
                // hold the look-ahead address through a stall
                ram_raddr  = {job_reg.bank, AW'({1'b0, idx_reg} + (KW+1)'(2))};
                out_load   = slot_free;
                done.valid = slot_free && is_last;
            end
            egcn_pkg::B_ERR: begin
                out_load   = slot_free;
                out_err    = 1'b1;
                done.valid = slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= egcn_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
            k_reg   <= KW'(head_job.k);
        end
        case (state_reg)
            egcn_pkg::B_START: begin
                thresh_reg <= (job_reg.min_sep > scaled) ? job_reg.min_sep : scaled;
            end
            egcn_pkg::B_LOAD0: begin
                cur_reg      <= ram_rdata;
                gap_left_reg <= egcn_pkg::SEP_MAX;
                idx_reg      <= '0;
            end
            egcn_pkg::B_CALC: begin
                nxt_reg       <= ram_rdata;
                gap_right_reg <= has_right ? gap_sat(cur_reg, ram_rdata) : egcn_pkg::SEP_MAX;
            end
            egcn_pkg::B_EMIT: begin
                if (slot_free && !is_last) begin
                    cur_reg      <= nxt_reg;
                    gap_left_reg <= gap_right_reg;
                    idx_reg      <= idx_reg + KW'(1);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            if (out_err) begin
                m_separation <= '0;
                m_index      <= '0;
                m_status     <= egcn_pkg::STATUS_ERR;
                m_last       <= 1'b1;
            end else begin
                m_separation <= sep;
                m_index      <= egcn_pkg::IDX_BITS'(idx_reg);
                m_status     <= egcn_pkg::STATUS_OK;
                m_last       <= is_last;
            end
        end
    end

    assign m_valid = m_valid_reg;

    a_run_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |=> (state_reg == egcn_pkg::B_IDLE))
        else $error("engine did not return to idle after a run");

    a_last_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !out_err && is_last) |-> done.valid)
        else $error("final result without bank release");

endmodule
